// ===== src/rate_limited_random_write_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rate limited random write generator
// Shared property wrappers; every use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RATE_LIMITED_RANDOM_WRITE_GENERATOR_DEFINES_SVH
`define RATE_LIMITED_RANDOM_WRITE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLWG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLWG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rlwg_pkg.sv =====
// ----------------------------------------------------------------------------
// rlwg_pkg
// Types, constants and helpers shared by the write generator modules.
// ----------------------------------------------------------------------------
package rlwg_pkg;

    localparam int unsigned ALU_W     = 64;
    localparam int unsigned ALU_CNT_W = $clog2(ALU_W);
    localparam int unsigned MB_SHIFT  = 20;
    localparam int unsigned MB_W      = 24;
    localparam int unsigned XS_A      = 12;
    localparam int unsigned XS_B      = 25;
    localparam int unsigned XS_C      = 27;

    typedef logic [63:0] word_t;
    typedef logic [47:0] time_t;
    typedef logic [39:0] bytes_t;
    typedef logic [43:0] wcount_t;
    typedef logic [51:0] durus_t;
    typedef logic [20:0] block_t;
    typedef logic [23:0] mb_t;
    typedef logic [2:0]  cfg_idx_t;

    localparam word_t DEFAULT_SEED = 64'h0123_4567_89AB_CDEF;
    localparam word_t RNG_MULT     = 64'd2685821657736338717;
    localparam time_t SEC_US       = 48'd1000000;
    localparam block_t BLOCK_RESET = 21'd4096;

    // Register indexes
    localparam cfg_idx_t REG_SEED     = 3'd0;
    localparam cfg_idx_t REG_BLOCK    = 3'd1;
    localparam cfg_idx_t REG_REGION   = 3'd2;
    localparam cfg_idx_t REG_WINDOW   = 3'd3;
    localparam cfg_idx_t REG_DURATION = 3'd4;
    localparam cfg_idx_t REG_RATE     = 3'd5;
    localparam cfg_idx_t REG_SYNC_MOD = 3'd6;
    localparam cfg_idx_t REG_SYNC_IVL = 3'd7;

    // Sync modes
    localparam logic [1:0] SYNC_NONE     = 2'd0;
    localparam logic [1:0] SYNC_ALWAYS   = 2'd1;
    localparam logic [1:0] SYNC_PERIODIC = 2'd2;

    // Input item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ATTEMPT = 1'b1;

    // Shared unit operations
    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    typedef struct packed {
        word_t       seed_value;
        block_t      block_bytes;
        bytes_t      region_bytes;
        bytes_t      window_bytes;
        durus_t      dur_us;
        bytes_t      rate_bytes_per_second;
        logic [1:0]  sync_mode;
        logic [31:0] sync_interval;
    } cfg_t;

    typedef struct packed {
        logic  start;
        logic  op;
        word_t a;
        word_t b;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t hi;
        word_t lo;
    } alu_rsp_t;

    typedef struct packed {
        logic   issued;
        bytes_t offset;
        logic   throttled;
        logic   finished;
        logic   sync_now;
        logic   report_valid;
        mb_t    report_megabytes;
    } result_t;

    function automatic word_t xorshift(input word_t x);
        word_t t;
        t = x ^ (x >> XS_A);
        t = t ^ (t << XS_B);
        t = t ^ (t >> XS_C);
        return t;
    endfunction

endpackage

// ===== src/rlwg_alu.sv =====
// ----------------------------------------------------------------------------
// rlwg_alu
// Shared bit-serial unit: 64-bit low-half multiply and restoring divide.
// ----------------------------------------------------------------------------
module rlwg_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  rlwg_pkg::alu_req_t  req,
    output rlwg_pkg::alu_rsp_t  rsp
);

    localparam logic [rlwg_pkg::ALU_CNT_W-1:0] CNT_MAX =
        rlwg_pkg::ALU_CNT_W'(rlwg_pkg::ALU_W - 1);

    logic                            busy_reg;
    logic                            done_reg;
    logic                            op_reg;
    logic [rlwg_pkg::ALU_CNT_W-1:0]  cnt_reg;
    rlwg_pkg::word_t                 x_reg;
    rlwg_pkg::word_t                 hi_reg;
    rlwg_pkg::word_t                 lo_reg;

    logic [rlwg_pkg::ALU_W:0]        div_trial;
    logic [rlwg_pkg::ALU_W:0]        div_diff;
    logic                            div_ge;
    rlwg_pkg::word_t                 div_rem;

    // One quotient bit per cycle; the remainder sits in hi_reg.
    always_comb
    begin
        div_trial = {hi_reg, lo_reg[rlwg_pkg::ALU_W-1]};
        div_ge    = div_trial >= {1'b0, x_reg};
        div_diff  = div_trial - {1'b0, x_reg};
        div_rem   = div_ge ? div_diff[rlwg_pkg::ALU_W-1:0] : div_trial[rlwg_pkg::ALU_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= rlwg_pkg::ALU_MUL;
            cnt_reg  <= '0;
            x_reg    <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= req.op;
                hi_reg   <= '0;
                if (req.op == rlwg_pkg::ALU_MUL)
                begin
                    x_reg  <= req.a;
                    lo_reg <= req.b;
                end
                else
                begin
                    x_reg  <= req.b;
                    lo_reg <= req.a;
                end
            end
            else if (busy_reg)
            begin
                if (op_reg == rlwg_pkg::ALU_MUL)
                begin
                    // Shift-add; stops as soon as no multiplier bits remain.
                    if (lo_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        if (lo_reg[0])
                        begin
                            hi_reg <= hi_reg + x_reg;
                        end
                        x_reg  <= x_reg << 1;
                        lo_reg <= lo_reg >> 1;
                    end
                end
                else
                begin
                    hi_reg  <= div_rem;
                    lo_reg  <= {lo_reg[rlwg_pkg::ALU_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_MAX)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hi   = hi_reg;
    assign rsp.lo   = lo_reg;

endmodule

// ===== src/rlwg_cfg.sv =====
// ----------------------------------------------------------------------------
// rlwg_cfg
// Configuration register file with the run length kept in microseconds.
// ----------------------------------------------------------------------------
module rlwg_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  rlwg_pkg::cfg_idx_t  cfg_index,
    input  rlwg_pkg::word_t     cfg_data,
    output rlwg_pkg::cfg_t      cfg
);

    rlwg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                       <= '0;
            cfg_reg.block_bytes           <= rlwg_pkg::BLOCK_RESET;
            cfg_reg.sync_interval         <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlwg_pkg::REG_SEED:     cfg_reg.seed_value   <= cfg_data;
                rlwg_pkg::REG_BLOCK:    cfg_reg.block_bytes  <= rlwg_pkg::block_t'(cfg_data);
                rlwg_pkg::REG_REGION:   cfg_reg.region_bytes <= rlwg_pkg::bytes_t'(cfg_data);
                rlwg_pkg::REG_WINDOW:   cfg_reg.window_bytes <= rlwg_pkg::bytes_t'(cfg_data);
                // Seconds are scaled once here so the run check is a plain compare.
                rlwg_pkg::REG_DURATION: cfg_reg.dur_us <=
                    rlwg_pkg::durus_t'(cfg_data[31:0]) * rlwg_pkg::durus_t'(rlwg_pkg::SEC_US);
                rlwg_pkg::REG_RATE:     cfg_reg.rate_bytes_per_second <=
                    rlwg_pkg::bytes_t'(cfg_data);
                rlwg_pkg::REG_SYNC_MOD: cfg_reg.sync_mode     <= cfg_data[1:0];
                rlwg_pkg::REG_SYNC_IVL: cfg_reg.sync_interval <= cfg_data[31:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rate_limited_random_write_generator.sv =====
// ----------------------------------------------------------------------------
// rate_limited_random_write_generator
// Token bucket write generator with xorshift64* block-aligned offsets.
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, kind, now_us          | in
//   result  | out_valid, out_ready, issued .. megabytes | out
//   config  | cfg_we, cfg_index, cfg_data               | in
//
// A start item goes straight to emit; a finished attempt passes the check state
// and a throttled one the check and refill states. A granted write runs the
// one-bit-per-cycle shared multiply/divide unit (random product, block count,
// offset remainder, offset product and, in periodic mode, the sync remainder).
// One item is in work at a time; in_ready is high only in the idle state.
// A finished result waits in the output register while the next item is taken.
// Reset restores the default seed and clears the bucket, times and counters.
// ----------------------------------------------------------------------------
`include "rate_limited_random_write_generator_defines.svh"

module rate_limited_random_write_generator (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  logic [47:0]             now_us,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    issued,
    output logic [39:0]             offset,
    output logic                    throttled,
    output logic                    finished,
    output logic                    sync_now,
    output logic                    report_valid,
    output logic [23:0]             report_megabytes,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHK     = 4'd1;
    localparam logic [3:0] S_REFILL  = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_DIV_BLK = 4'd4;
    localparam logic [3:0] S_DIV_OFF = 4'd5;
    localparam logic [3:0] S_MUL_OFF = 4'd6;
    localparam logic [3:0] S_UPD     = 4'd7;
    localparam logic [3:0] S_SYNC    = 4'd8;
    localparam logic [3:0] S_REP     = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    rlwg_pkg::cfg_t      cfg;
    rlwg_pkg::alu_req_t  req;
    rlwg_pkg::alu_rsp_t  rsp;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    rlwg_pkg::time_t     now_reg;
    rlwg_pkg::word_t     rng_reg;
    rlwg_pkg::word_t     r_reg;
    rlwg_pkg::time_t     start_reg;
    rlwg_pkg::time_t     refill_reg;
    rlwg_pkg::time_t     report_reg;
    rlwg_pkg::bytes_t    bucket_reg;
    rlwg_pkg::word_t     total_reg;
    rlwg_pkg::wcount_t   wcount_reg;
    logic                done_reg;
    rlwg_pkg::result_t   res_reg;
    rlwg_pkg::result_t   out_res_reg;
    logic                out_valid_reg;

    rlwg_pkg::bytes_t    window;
    rlwg_pkg::time_t     elapsed_run;
    rlwg_pkg::time_t     elapsed_fill;
    logic                run_over;
    logic                refill_due;
    rlwg_pkg::bytes_t    bucket_eff;
    logic                bucket_short;
    rlwg_pkg::word_t     rng_mixed;
    rlwg_pkg::wcount_t   wcount_inc;
    logic                out_free;

    rlwg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlwg_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        window       = (cfg.window_bytes > cfg.region_bytes) ? cfg.region_bytes
                                                             : cfg.window_bytes;
        elapsed_run  = now_reg - start_reg;
        elapsed_fill = now_reg - refill_reg;
        run_over     = rlwg_pkg::durus_t'(elapsed_run) >= cfg.dur_us;
        refill_due   = elapsed_fill >= rlwg_pkg::SEC_US;
        bucket_eff   = refill_due ? cfg.rate_bytes_per_second : bucket_reg;
        bucket_short = bucket_eff < rlwg_pkg::bytes_t'(cfg.block_bytes);
        rng_mixed    = rlwg_pkg::xorshift(rng_reg);
        wcount_inc   = wcount_reg + 1'b1;
        out_free     = !out_valid_reg || out_ready;
    end

    // Sequencer: next state and launches of the shared unit.
    always_comb
    begin
        state_next = state_reg;
        req        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (kind == rlwg_pkg::KIND_START) ? S_EMIT : S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = (done_reg || run_over) ? S_EMIT : S_REFILL;
            end
            S_REFILL:
            begin
                if (bucket_short)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    req.start  = 1'b1;
                    req.op     = rlwg_pkg::ALU_MUL;
                    req.a      = rng_mixed;
                    req.b      = rlwg_pkg::RNG_MULT;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (rsp.done)
                begin
                    if (cfg.block_bytes == '0)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.op     = rlwg_pkg::ALU_DIV;
                        req.a      = rlwg_pkg::word_t'(window);
                        req.b      = rlwg_pkg::word_t'(cfg.block_bytes);
                        state_next = S_DIV_BLK;
                    end
                end
            end
            S_DIV_BLK:
            begin
                if (rsp.done)
                begin
                    // A window smaller than one block leaves the offset at zero.
                    if (rsp.lo == '0)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.op     = rlwg_pkg::ALU_DIV;
                        req.a      = r_reg;
                        req.b      = rsp.lo;
                        state_next = S_DIV_OFF;
                    end
                end
            end
            S_DIV_OFF:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = rlwg_pkg::ALU_MUL;
                    req.a      = rsp.hi;
                    req.b      = rlwg_pkg::word_t'(cfg.block_bytes);
                    state_next = S_MUL_OFF;
                end
            end
            S_MUL_OFF:
            begin
                if (rsp.done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (cfg.sync_mode == rlwg_pkg::SYNC_PERIODIC && cfg.sync_interval != '0)
                begin
                    req.start  = 1'b1;
                    req.op     = rlwg_pkg::ALU_DIV;
                    req.a      = rlwg_pkg::word_t'(wcount_inc);
                    req.b      = rlwg_pkg::word_t'(cfg.sync_interval);
                    state_next = S_SYNC;
                end
                else
                begin
                    state_next = S_REP;
                end
            end
            S_SYNC:
            begin
                if (rsp.done)
                begin
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            rng_reg       <= rlwg_pkg::DEFAULT_SEED;
            r_reg         <= '0;
            start_reg     <= '0;
            refill_reg    <= '0;
            report_reg    <= '0;
            bucket_reg    <= '0;
            total_reg     <= '0;
            wcount_reg    <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
            out_res_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg <= now_us;
                        res_reg <= '0;
                        if (kind == rlwg_pkg::KIND_START)
                        begin
                            start_reg  <= now_us;
                            refill_reg <= now_us;
                            report_reg <= now_us + rlwg_pkg::SEC_US;
                            bucket_reg <= cfg.rate_bytes_per_second;
                            rng_reg    <= (cfg.seed_value != '0) ? cfg.seed_value
                                                                 : rlwg_pkg::DEFAULT_SEED;
                            total_reg  <= '0;
                            wcount_reg <= '0;
                            done_reg   <= 1'b0;
                        end
                    end
                end
                S_CHK:
                begin
                    if (done_reg)
                    begin
                        res_reg.finished <= 1'b1;
                    end
                    else if (run_over)
                    begin
                        // First attempt past the run length carries the final flush.
                        done_reg         <= 1'b1;
                        res_reg.finished <= 1'b1;
                        res_reg.sync_now <= (cfg.sync_mode == rlwg_pkg::SYNC_ALWAYS) ||
                                            (cfg.sync_mode == rlwg_pkg::SYNC_PERIODIC);
                    end
                end
                S_REFILL:
                begin
                    if (refill_due)
                    begin
                        bucket_reg <= cfg.rate_bytes_per_second;
                        refill_reg <= now_reg;
                    end
                    if (bucket_short)
                    begin
                        res_reg.throttled <= 1'b1;
                    end
                    else
                    begin
                        rng_reg <= rng_mixed;
                    end
                end
                S_MUL:
                begin
                    if (rsp.done)
                    begin
                        r_reg <= rsp.hi;
                    end
                end
                S_MUL_OFF:
                begin
                    if (rsp.done)
                    begin
                        res_reg.offset <= rlwg_pkg::bytes_t'(rsp.hi);
                    end
                end
                S_UPD:
                begin
                    total_reg        <= total_reg + rlwg_pkg::word_t'(cfg.block_bytes);
                    bucket_reg       <= bucket_reg - rlwg_pkg::bytes_t'(cfg.block_bytes);
                    wcount_reg       <= wcount_inc;
                    res_reg.issued   <= 1'b1;
                    res_reg.sync_now <= cfg.sync_mode == rlwg_pkg::SYNC_ALWAYS;
                end
                S_SYNC:
                begin
                    if (rsp.done)
                    begin
                        res_reg.sync_now <= rsp.hi == '0;
                    end
                end
                S_REP:
                begin
                    if (now_reg >= report_reg)
                    begin
                        res_reg.report_valid     <= 1'b1;
                        res_reg.report_megabytes <=
                            total_reg[rlwg_pkg::MB_SHIFT +: rlwg_pkg::MB_W];
                        report_reg               <= now_reg + rlwg_pkg::SEC_US;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_res_reg   <= res_reg;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready         = state_reg == S_IDLE;
    assign out_valid        = out_valid_reg;
    assign issued           = out_res_reg.issued;
    assign offset           = out_res_reg.offset;
    assign throttled        = out_res_reg.throttled;
    assign finished         = out_res_reg.finished;
    assign sync_now         = out_res_reg.sync_now;
    assign report_valid     = out_res_reg.report_valid;
    assign report_megabytes = out_res_reg.report_megabytes;

    `RLWG_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready,
        "input taken again before the item in work finished")
    `RLWG_ASSERT_SAME(a_outcome_excl, out_valid && issued, !throttled && !finished,
        "granted write also marked throttled or finished")
    `RLWG_ASSERT_SAME(a_offset_window, out_valid && issued, offset == '0 || offset < window,
        "granted offset lies outside the window")
    `RLWG_ASSERT_SAME(a_alu_done_wait, rsp.done,
        state_reg == S_MUL || state_reg == S_DIV_BLK || state_reg == S_DIV_OFF ||
        state_reg == S_MUL_OFF || state_reg == S_SYNC,
        "shared unit finished while the sequencer was not waiting on it")

endmodule
